// ===== design/smbs_pkg.sv =====
// smbs_pkg: types, constants and helpers shared by the sorted-matrix search block
// no dependencies; compile first
`default_nettype none

package smbs_pkg;

  // matrix geometry
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 16;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int CNT_W       = ADDR_W + 1;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int DATA_W      = 32;
  localparam int DIM_W       = 5;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = DIM_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0] ROWS_RESET = DIM_W'(MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_RESET = DIM_W'(MAX_COLS);

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // reciprocal table for index / column count: floor(2^RECIP_SHIFT / n)
  localparam int RECIP_SHIFT = 12;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP_TBL [0:16] = '{
    13'd0,    13'd4096, 13'd2048, 13'd1365, 13'd1024, 13'd819, 13'd682,
    13'd585,  13'd512,  13'd455,  13'd409,  13'd372,  13'd341, 13'd315,
    13'd292,  13'd273,  13'd256
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_DIV,
    ST_CMP,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic wr_en;
    logic mid_en;
    logic div_en;
    logic cmp_en;
    logic rsp_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic hit;
    logic out_busy;
  } sts_t;

  // zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/smbs_req_if.sv =====
// smbs_req_if: request channel (write or search word)
// depends on smbs_pkg
`default_nettype none

interface smbs_req_if
  import smbs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [DATA_W-1:0] entry_value;
  logic signed [DATA_W-1:0] target;

  modport source (output valid, req_type, row, col, entry_value, target, input ready);
  modport sink   (input valid, req_type, row, col, entry_value, target, output ready);
endinterface

`default_nettype wire

// ===== design/smbs_rsp_if.sv =====
// smbs_rsp_if: response channel carrying the found flag
// no dependencies
`default_nettype none

interface smbs_rsp_if;
  logic valid;
  logic ready;
  logic found;

  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

`default_nettype wire

// ===== design/smbs_cfg_if.sv =====
// smbs_cfg_if: configuration write channel (register index and data)
// depends on smbs_pkg
`default_nettype none

interface smbs_cfg_if
  import smbs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/smbs_ctrl.sv =====
// smbs_ctrl: state machine that sequences the binary-search probes
// depends on smbs_pkg
`default_nettype none

module smbs_ctrl
  import smbs_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   req_valid_i,
  input  wire   req_type_i,
  output logic  req_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = req_valid_i && (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_type_i == REQ_SEARCH)) state_d = ST_MID;
      end
      ST_MID: begin
        state_d = sts_i.empty ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = sts_i.hit ? ST_DONE : ST_MID;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.wr_en  = accept && (req_type_i == REQ_WRITE);
        cmd_o.start  = accept && (req_type_i == REQ_SEARCH);
      end
      ST_MID:  cmd_o.mid_en   = !sts_i.empty;
      ST_DIV:  cmd_o.div_en   = 1'b1;
      ST_CMP:  cmd_o.cmp_en   = 1'b1;
      ST_DONE: cmd_o.rsp_load = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/smbs_dp.sv =====
// smbs_dp: matrix store, config registers, probe index split and compare
// depends on smbs_pkg
`default_nettype none

module smbs_dp
  import smbs_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  wire [ROW_W-1:0]          row_i,
  input  wire [COL_W-1:0]          col_i,
  input  wire signed [DATA_W-1:0]  entry_value_i,
  input  wire signed [DATA_W-1:0]  target_i,
  input  wire                      cfg_valid_i,
  input  wire [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [CFG_DATA_W-1:0]     cfg_data_i,
  output logic                     rsp_valid_o,
  input  wire                      rsp_ready_i,
  output logic                     rsp_found_o
);

  localparam int PROD_W = ADDR_W + RECIP_W;
  localparam int QN_W   = ROW_W + DIM_W;

  logic [DIM_W-1:0]          rows_q, cols_q, nr, nc;
  logic [2*DIM_W-1:0]        span;
  logic [CNT_W-1:0]          lo_q, hi_q;
  logic [CNT_W:0]            mid_sum;
  logic [ADDR_W-1:0]         mid_q;
  logic [PROD_W-1:0]         prod_q;
  logic [RECIP_W-1:0]        recip;
  logic [ROW_W-1:0]          q_est, q_row;
  logic [QN_W-1:0]           qn;
  logic [CNT_W-1:0]          rem, rem_fix;
  logic                      fix;
  logic [COL_W-1:0]          q_col;
  logic [ADDR_W-1:0]         rd_addr;
  logic signed [DATA_W-1:0]  target_q, rdata_q;
  logic signed [DATA_W-1:0]  mem_q [STORE_DEPTH];
  logic                      found_q, out_valid_q, out_found_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROWS: rows_q <= cfg_data_i;
        CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr   = clamp_dim(rows_q, DIM_W'(MAX_ROWS));
  assign nc   = clamp_dim(cols_q, DIM_W'(MAX_COLS));
  assign span = {{DIM_W{1'b0}}, nr} * {{DIM_W{1'b0}}, nc};

  // middle of the live range, hi_q is exclusive
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
  assign recip   = RECIP_TBL[nc];

  // quotient estimate is exact or one short: one correction step
  assign q_est   = prod_q[RECIP_SHIFT +: ROW_W];
  assign qn      = {{DIM_W{1'b0}}, q_est} * {{ROW_W{1'b0}}, nc};
  assign rem     = {1'b0, mid_q} - qn[CNT_W-1:0];
  assign fix     = rem >= {{(CNT_W - DIM_W){1'b0}}, nc};
  assign rem_fix = rem - {{(CNT_W - DIM_W){1'b0}}, nc};
  assign q_row   = fix ? q_est + ROW_W'(1) : q_est;
  assign q_col   = fix ? rem_fix[COL_W-1:0] : rem[COL_W-1:0];
  assign rd_addr = {q_row, q_col};

  // search range, probe index and product
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      lo_q     <= '0;
      hi_q     <= span[CNT_W-1:0];
      target_q <= target_i;
    end else if (cmd_i.cmp_en) begin
      if (rdata_q < target_q) begin
        lo_q <= {1'b0, mid_q} + CNT_W'(1);
      end else if (rdata_q > target_q) begin
        hi_q <= {1'b0, mid_q};
      end
    end
    if (cmd_i.mid_en) begin
      mid_q  <= mid_sum[ADDR_W:1];
      prod_q <= {{RECIP_W{1'b0}}, mid_sum[ADDR_W:1]} * {{ADDR_W{1'b0}}, recip};
    end
  end

  // matrix store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[{row_i, col_i}] <= entry_value_i;
    end
    if (cmd_i.div_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // hit flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (cmd_i.cmp_en && (rdata_q == target_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.rsp_load) begin
        out_valid_q <= 1'b1;
        out_found_q <= found_q;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.empty    = lo_q >= hi_q;
  assign sts_o.hit      = rdata_q == target_q;
  assign sts_o.out_busy = out_valid_q && !rsp_ready_i;
  assign rsp_valid_o    = out_valid_q;
  assign rsp_found_o    = out_found_q;

endmodule

`default_nettype wire

// ===== design/sorted_matrix_binary_search_top.sv =====
// sorted_matrix_binary_search_top: binary search over a row-major sorted matrix
// depends on smbs_pkg, smbs_req_if, smbs_rsp_if, smbs_cfg_if, smbs_ctrl, smbs_dp
//
//   port    dir  word                                        notes
//   req_i   in   req_type, row, col, entry_value, target     write or search
//   cfg_i   in   index, data                                 rows_in_use / cols_in_use
//   rsp_o   out  found                                       one word per search
//
// a write is taken in the idle state; a search runs the probe loop (ST_MID, ST_DIV,
// ST_CMP) until a hit or an empty range: index split by reciprocal multiply,
// store read, compare
// one item is worked on at a time; writes keep flowing while a result waits in rsp_o
// a stalled result holds the search state machine in its final state
// reset clears control and the config registers (16 x 16); the store is not cleared
`default_nettype none

module sorted_matrix_binary_search_top
  import smbs_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  smbs_req_if.sink       req_i,
  smbs_cfg_if.sink       cfg_i,
  smbs_rsp_if.source     rsp_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  smbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smbs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .row_i         (req_i.row),
    .col_i         (req_i.col),
    .entry_value_i (req_i.entry_value),
    .target_i      (req_i.target),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_found_o   (rsp_o.found)
  );

endmodule

`default_nettype wire

// ===== design/smbs_chk.sv =====
// smbs_chk: port-level checks on the sorted-matrix search block, with its bind
// depends on smbs_pkg and sorted_matrix_binary_search_top
`default_nettype none

module smbs_chk
  import smbs_pkg::*;
(
  input wire clk_i,
  input wire rst_ni,
  input wire req_valid,
  input wire req_ready,
  input wire req_type,
  input wire rsp_valid,
  input wire rsp_ready,
  input wire rsp_found
);

  // stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // stalled result keeps its flag
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_found))
    else $error("response flag changed while stalled");

  // a search holds off further requests once taken
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && (req_type == REQ_SEARCH) |=> !req_ready)
    else $error("request taken right after a search");

  // a write completes in its own cycle
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && (req_type == REQ_WRITE) |=> req_ready)
    else $error("write stalled the request channel");

  // a new result only comes out of a running search
  a_rsp_from_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response without a search in progress");

endmodule

bind sorted_matrix_binary_search_top smbs_chk u_smbs_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .req_type  (req_i.req_type),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_found (rsp_o.found)
);

`default_nettype wire

// ===== sim/sorted_matrix_binary_search_top_tb.sv =====
// sorted_matrix_binary_search_top_tb: self-checking bench for the sorted-matrix search block
// drives write/search and config words, predicts each found flag and compares in order
// depends on smbs_pkg, smbs_req_if, smbs_rsp_if, smbs_cfg_if and the design top level
`default_nettype none

module sorted_matrix_binary_search_top_tb
  import smbs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1300;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 50;
  localparam int DIRECTED_N     = 27;
  localparam int FORCED_N       = 6;

  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // register indexes past the defined ones
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_COLS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

  // shapes visited first: full, saturated, one row, one column, zero acting as one
  localparam logic [DIM_W-1:0] FORCED_ROWS [FORCED_N] = '{16, 31, 1, 16, 0, 3};
  localparam logic [DIM_W-1:0] FORCED_COLS [FORCED_N] = '{16, 31, 16, 1, 5, 0};

  typedef struct {
    logic                     req_type;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] target;
  } req_word_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    req_word_t             word;
    bit                    typed;
    logic                  typed_found;
  } step_t;

  typedef enum int {PACE_OPEN, PACE_COIN, PACE_DUTY, PACE_SPARSE} pace_e;

  logic clk_i;
  logic rst_ni;

  smbs_req_if req_if ();
  smbs_cfg_if cfg_if ();
  smbs_rsp_if rsp_if ();

  sorted_matrix_binary_search_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cfg_i  (cfg_if),
    .rsp_o  (rsp_if)
  );

  // bench copy of the block state
  logic signed [DATA_W-1:0] store_mirror [STORE_DEPTH];
  bit                       written_map  [STORE_DEPTH];
  logic [DIM_W-1:0]         rows_cfg = ROWS_RESET;
  logic [DIM_W-1:0]         cols_cfg = COLS_RESET;

  logic found_q [$];
  int   err_count   = 0;
  int   items_sent  = 0;
  int   rsp_count   = 0;
  int   burst_left  = 0;
  int   quiet_count = 0;

  step_t directed_steps [DIRECTED_N];

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // used extent of one dimension: zero acts as one, large values saturate
  function automatic int dim_used(input logic [DIM_W-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  // binary search over the flat used region, as the block runs it
  function automatic logic find_target(input logic signed [DATA_W-1:0] tgt);
    int nr;
    int nc;
    int lo;
    int hi;
    int mid;
    logic signed [DATA_W-1:0] v;
    nr = dim_used(rows_cfg, MAX_ROWS);
    nc = dim_used(cols_cfg, MAX_COLS);
    lo = 0;
    hi = nr * nc - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v = store_mirror[(mid / nc) * MAX_COLS + (mid % nc)];
      if (v == tgt) return 1'b1;
      if (v < tgt) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  // every entry a search may probe has been written
  function automatic bit region_written();
    int r;
    int c;
    for (r = 0; r < dim_used(rows_cfg, MAX_ROWS); r++) begin
      for (c = 0; c < dim_used(cols_cfg, MAX_COLS); c++) begin
        if (!written_map[r * MAX_COLS + c]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic req_word_t write_word(input int r, input int c,
                                           input logic signed [DATA_W-1:0] v);
    req_word_t w;
    w.req_type    = REQ_WRITE;
    w.row         = ROW_W'(r);
    w.col         = COL_W'(c);
    w.entry_value = v;
    w.target      = $urandom;
    return w;
  endfunction

  function automatic req_word_t search_word(input logic signed [DATA_W-1:0] t);
    req_word_t w;
    w.req_type    = REQ_SEARCH;
    w.row         = ROW_W'($urandom);
    w.col         = COL_W'($urandom);
    w.entry_value = $urandom;
    w.target      = t;
    return w;
  endfunction

  function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.index  = idx;
    s.data   = val;
    return s;
  endfunction

  function automatic step_t wr_step(input int r, input int c,
                                    input logic signed [DATA_W-1:0] v);
    step_t s;
    s = '{default: '0};
    s.word = write_word(r, c, v);
    return s;
  endfunction

  function automatic step_t find_step(input logic signed [DATA_W-1:0] t, input bit typed,
                                      input logic f);
    step_t s;
    s = '{default: '0};
    s.word        = search_word(t);
    s.typed       = typed;
    s.typed_found = f;
    return s;
  endfunction

  // offer one request word in bursts; update the mirror or queue the found flag on accept
  task automatic offer_req(input req_word_t w, input bit typed, input logic typed_found);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= w.req_type;
    req_if.row         <= w.row;
    req_if.col         <= w.col;
    req_if.entry_value <= w.entry_value;
    req_if.target      <= w.target;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    if (w.req_type == REQ_WRITE) begin
      store_mirror[int'(w.row) * MAX_COLS + int'(w.col)] = w.entry_value;
      written_map[int'(w.row) * MAX_COLS + int'(w.col)]  = 1'b1;
    end else begin
      found_q.push_back(typed ? typed_found : find_target(w.target));
    end
  endtask

  // stop offering, let every pending search come back, then let the block go quiet
  task automatic settle();
    req_if.valid <= 1'b0;
    while (found_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                           input bit last);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      CFG_ROWS: rows_cfg = val;
      CFG_COLS: cols_cfg = val;
      default: ;
    endcase
    if (last) cfg_if.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_count++;
      if (found_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINTS)
          $display("%0t: found word with nothing pending, expected none actual %0b",
                   $time, rsp_if.found);
      end else begin
        if (rsp_if.found !== found_q[0]) begin
          err_count++;
          if (err_count <= MAX_PRINTS)
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, found_q[0], rsp_if.found);
        end
        void'(found_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (rsp_if.valid && rsp_if.ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver pacing, with two long hold-offs to back the block up
  initial begin : rsp_pacing
    int    seg;
    int    k;
    pace_e pace;
    bit    held_early;
    bit    held_late;
    held_early = 1'b0;
    held_late  = 1'b0;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ((!held_early && rsp_count >= 150) || (!held_late && rsp_count >= 700)) begin
        if (held_early) held_late = 1'b1;
        held_early = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pace = pace_e'($urandom_range(0, 3));
      seg  = $urandom_range(20, 200);
      for (k = 0; k < seg; k++) begin
        case (pace)
          PACE_OPEN:   rsp_if.ready <= 1'b1;
          PACE_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
          PACE_DUTY:   rsp_if.ready <= ((k % 7) < 4);
          default:     rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // main stimulus
  initial begin : stimulus
    int i;
    int k;
    int n;
    int nr;
    int nc;
    int r;
    int c;
    int pos;
    int phase;
    int fill_mode;
    int item_count;
    bit keep_sorted;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] fill_vals [$];
    logic [DIM_W-1:0] rows_next;
    logic [DIM_W-1:0] cols_next;

    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_WRITE;
    req_if.row         <= '0;
    req_if.col         <= '0;
    req_if.entry_value <= '0;
    req_if.target      <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_ROWS;
    cfg_if.data        <= '0;
    for (i = 0; i < STORE_DEPTH; i++) written_map[i] = 1'b0;

    // directed steps: 1x1 extremes, then small sorted and unsorted shapes
    directed_steps = '{
      cfg_step(CFG_ROWS, '0),
      cfg_step(CFG_COLS, '0),
      wr_step(0, 0, VAL_MIN),
      find_step(VAL_MIN, 1'b1, 1'b1),
      find_step(VAL_MAX, 1'b1, 1'b0),
      wr_step(0, 0, VAL_MAX),
      find_step(VAL_MAX, 1'b1, 1'b1),
      find_step(VAL_MIN, 1'b1, 1'b0),
      cfg_step(CFG_COLS, CFG_DATA_W'(2)),
      wr_step(0, 0, -5),
      wr_step(0, 1, 9),
      find_step(-5, 1'b0, 1'b0),
      find_step(9, 1'b0, 1'b0),
      find_step(0, 1'b0, 1'b0),
      cfg_step(CFG_ROWS, CFG_DATA_W'(2)),
      wr_step(1, 0, 20),
      wr_step(1, 1, 100),
      find_step(100, 1'b0, 1'b0),
      find_step(21, 1'b0, 1'b0),
      cfg_step(CFG_LAST_UNUSED, '1),
      find_step(20, 1'b0, 1'b0),
      wr_step(15, 15, -1),
      find_step(-1, 1'b0, 1'b0),
      wr_step(0, 0, 500),
      find_step(500, 1'b0, 1'b0),
      find_step(20, 1'b0, 1'b0),
      find_step(9, 1'b0, 1'b0)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIRECTED_N; i++) begin
      if (directed_steps[i].is_cfg) begin
        settle();
        write_reg(directed_steps[i].index, directed_steps[i].data, 1'b1);
      end else begin
        offer_req(directed_steps[i].word, directed_steps[i].typed,
                  directed_steps[i].typed_found);
      end
    end

    // random phases: new shape, sorted fill of the used region, then mostly searches
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase < FORCED_N) begin
        rows_next = FORCED_ROWS[phase];
        cols_next = FORCED_COLS[phase];
      end else begin
        rows_next = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 31))
                                                : DIM_W'($urandom_range(1, 6));
        cols_next = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 31))
                                                : DIM_W'($urandom_range(1, 6));
      end
      phase++;

      settle();
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_FIRST_UNUSED), int'(CFG_LAST_UNUSED))),
                  CFG_DATA_W'($urandom), 1'b0);
      write_reg(CFG_ROWS, rows_next, 1'b0);
      write_reg(CFG_COLS, cols_next, 1'b1);

      nr = dim_used(rows_cfg, MAX_ROWS);
      nc = dim_used(cols_cfg, MAX_COLS);
      n  = nr * nc;

      // fill: mostly sorted, sometimes left unsorted
      if (!region_written() || (n <= 64 && $urandom_range(0, 1) == 1)) begin
        fill_mode   = $urandom_range(0, 2);
        keep_sorted = ($urandom_range(0, 7) != 0);
        fill_vals.delete();
        for (k = 0; k < n; k++) begin
          case (fill_mode)
            0: v = $urandom;
            1: v = $urandom_range(0, 15) - 8;
            default: begin
              case ($urandom_range(0, 4))
                0: v = VAL_MIN;
                1: v = VAL_MIN + 1;
                2: v = '0;
                3: v = VAL_MAX - 1;
                default: v = VAL_MAX;
              endcase
            end
          endcase
          pos = fill_vals.size();
          if (keep_sorted) begin
            while (pos > 0 && fill_vals[pos-1] > v) pos--;
          end
          fill_vals.insert(pos, v);
        end
        for (k = 0; k < n; k++)
          offer_req(write_word(k / nc, k % nc, fill_vals[k]), 1'b0, 1'b0);
      end

      // searches with the odd stray write
      item_count = $urandom_range(20, 60);
      for (k = 0; k < item_count; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          r = $urandom_range(0, MAX_ROWS - 1);
          c = $urandom_range(0, MAX_COLS - 1);
          if (r < nr && c < nc && $urandom_range(0, 3) != 0)
            v = store_mirror[r * MAX_COLS + c];
          else
            v = $urandom;
          offer_req(write_word(r, c, v), 1'b0, 1'b0);
        end else begin
          pos = $urandom_range(0, n - 1);
          v   = store_mirror[(pos / nc) * MAX_COLS + (pos % nc)];
          case ($urandom_range(0, 7))
            0, 1, 2, 3: t = v;
            4: t = v + 1;
            5: t = v - 1;
            6: t = $urandom;
            default: t = ($urandom_range(0, 1) == 1) ? VAL_MIN : VAL_MAX;
          endcase
          offer_req(search_word(t), 1'b0, 1'b0);
        end
      end
    end

    settle();
    if (err_count == 0 && found_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
